// File: rtl/crcfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcfr_pkg: shared definitions for the CRC-16 frame receiver
// Frame phases, result codes, the result record and the byte-wide
// CRC-16/MODBUS update.
// ----------------------------------------------------------------------------
package crcfr_pkg;

	// Frame phases of the receive sequencer.
	typedef enum logic [2:0] {
		PH_HUNT_A5 = 3'd0,
		PH_HUNT_5A = 3'd1,
		PH_LEN     = 3'd2,
		PH_CMD     = 3'd3,
		PH_DATA    = 3'd4,
		PH_CRC_HI  = 3'd5,
		PH_CRC_LO  = 3'd6
	} phase_t;

	// End-of-frame status codes.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CRC_ERR  = 2'd1,
		ST_TOO_LONG = 2'd2
	} status_t;

	// Result kinds.
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Header bytes and CRC constants.
	localparam logic [7:0]  HDR_BYTE0   = 8'hA5;
	localparam logic [7:0]  HDR_BYTE1   = 8'h5A;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [7:0]  MAX_PAY_RST = 8'hFF;

	// One result record as it leaves the sequencer.
	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [7:0]  byte_index;
		logic [7:0]  command;
		logic [7:0]  length;
		status_t     status;
		logic [15:0] first_word;
	} result_t;

	// Reflected CRC-16 update over one byte, eight shift steps.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// CRC after the two header bytes.
	localparam logic [15:0] CRC_AFTER_HDR = crc_byte(crc_byte(CRC_INIT, HDR_BYTE0), HDR_BYTE1);

endpackage
`default_nettype wire

// File: rtl/crcfr_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcfr_deframer: input register and frame sequencer
// Registers each accepted byte, then runs header hunt, length, command,
// payload and CRC check in one pass, producing at most one result per byte.
// ----------------------------------------------------------------------------
module crcfr_deframer
	import crcfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	input  wire logic [7:0] in_byte,
	output logic            in_ready,
	input  wire logic       out_free,
	output logic            res_valid,
	output result_t         res
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [7:0]  max_pay_q;
	phase_t      phase_q, phase_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [7:0]  crch_q, crch_d;
	logic [15:0] word_q, word_d;
	logic        emit;
	logic        advance;
	logic [15:0] crc_next;

	// The registered byte moves on when its result, if any, has room.
	assign advance   = valid_s1 && (!emit || out_free);
	assign in_ready  = !valid_s1 || advance;
	assign res_valid = advance && emit;
	assign crc_next  = crc_byte(crc_q, byte_s1);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pay_q <= MAX_PAY_RST;
		end else if (cfg_valid) begin
			max_pay_q <= cfg_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT_A5;
			crc_q   <= CRC_INIT;
			len_q   <= '0;
			cmd_q   <= '0;
			cnt_q   <= '0;
			crch_q  <= '0;
			word_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			crc_q   <= crc_d;
			len_q   <= len_d;
			cmd_q   <= cmd_d;
			cnt_q   <= cnt_d;
			crch_q  <= crch_d;
			word_q  <= word_d;
		end
	end

	// Next state and result for the registered byte.
	always_comb begin
		phase_d        = phase_q;
		crc_d          = crc_q;
		len_d          = len_q;
		cmd_d          = cmd_q;
		cnt_d          = cnt_q;
		crch_d         = crch_q;
		word_d         = word_q;
		emit           = 1'b0;
		res.kind       = KIND_DATA;
		res.data_byte  = '0;
		res.byte_index = '0;
		res.command    = cmd_q;
		res.length     = len_q;
		res.status     = ST_OK;
		res.first_word = '0;
		case (phase_q)
			PH_HUNT_A5: begin
				if (byte_s1 == HDR_BYTE0) begin
					phase_d = PH_HUNT_5A;
				end
			end
			PH_HUNT_5A: begin
				if (byte_s1 == HDR_BYTE1) begin
					crc_d   = CRC_AFTER_HDR;
					phase_d = PH_LEN;
				end else if (byte_s1 != HDR_BYTE0) begin
					phase_d = PH_HUNT_A5;
				end
			end
			PH_LEN: begin
				len_d   = byte_s1;
				crc_d   = crc_next;
				phase_d = PH_CMD;
			end
			PH_CMD: begin
				cmd_d       = byte_s1;
				crc_d       = crc_next;
				cnt_d       = '0;
				word_d      = '0;
				res.command = byte_s1;
				if (len_q > max_pay_q) begin
					phase_d    = PH_HUNT_A5;
					emit       = 1'b1;
					res.kind   = KIND_END;
					res.status = ST_TOO_LONG;
				end else if (len_q == 8'd0) begin
					phase_d = PH_CRC_HI;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				crc_d = crc_next;
				if (cnt_q == 8'd0) begin
					word_d = {byte_s1, word_q[7:0]};
				end else if (cnt_q == 8'd1) begin
					word_d = {word_q[15:8], byte_s1};
				end
				emit           = 1'b1;
				res.data_byte  = byte_s1;
				res.byte_index = cnt_q;
				cnt_d          = cnt_q + 8'd1;
				if (cnt_d == len_q) begin
					phase_d = PH_CRC_HI;
				end
			end
			PH_CRC_HI: begin
				crch_d  = byte_s1;
				phase_d = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				phase_d        = PH_HUNT_A5;
				emit           = 1'b1;
				res.kind       = KIND_END;
				res.status     = ({crch_q, byte_s1} == crc_q) ? ST_OK : ST_CRC_ERR;
				res.first_word = word_q;
			end
			default: begin
				phase_d = PH_HUNT_A5;
			end
		endcase
	end

`ifndef SYNTH
	// Payload results come only from the payload phase.
	a_data_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.kind == KIND_DATA) |-> phase_q == PH_DATA)
		else $error("payload result outside payload phase");

	// The payload counter stays below the frame length.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> cnt_q < len_q)
		else $error("payload counter reached frame length");

	// Hunting never produces a result.
	a_hunt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HUNT_A5 || phase_q == PH_HUNT_5A) |-> !emit)
		else $error("result while hunting for header");

	// The CRC low byte closes the frame and restarts the hunt.
	a_crc_lo_end: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (phase_q == PH_CRC_LO) |=> phase_q == PH_HUNT_A5)
		else $error("frame did not close after CRC low byte");
`endif

endmodule
`default_nettype wire

// File: rtl/crcfr_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcfr_out_reg: result register
// Holds one result until the consumer takes it; reports when it can load.
// ----------------------------------------------------------------------------
module crcfr_out_reg
	import crcfr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    res_valid,
	input  result_t      res,
	output logic         out_free,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_res
);

	logic    valid_q;
	result_t res_q;

	// Free when empty or when the held request leaves this cycle.
	assign out_free  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

// File: rtl/crc16_frame_receiver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc16_frame_receiver: streaming deframer with CRC-16/MODBUS check
// Top level: input register and sequencer, followed by the result register.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle when the result side does not stall and
// returns at most one result per byte via input, then result register. The
// byte-wide CRC update and the frame sequencer sit in a single stage between
// those registers, so with the output side ready a byte is accepted in every
// cycle. Frames are A5 5A LEN CMD payload CRC_HI CRC_LO; payload bytes are
// passed out as they arrive and each frame ends with one end result carrying
// ok, CRC mismatch or too long. max_payload resets to 255; the user writes it
// over the cfg channel while the receiver is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module crc16_frame_receiver
	import crcfr_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [7:0]   cfg_data,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [7:0]   rx_byte,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic              kind,
	output logic [7:0]        data_byte,
	output logic [7:0]        byte_index,
	output logic [7:0]        command,
	output logic [7:0]        length,
	output logic [1:0]        status,
	output logic signed [15:0] first_word
);

	logic    res_valid;
	logic    out_free;
	result_t res;
	result_t out_res;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	crcfr_deframer u_deframer (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_byte   (rx_byte),
		.in_ready  (in_ready),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res)
	);

	crcfr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	// Result fields onto the ports.
	assign kind       = out_res.kind;
	assign data_byte  = out_res.data_byte;
	assign byte_index = out_res.byte_index;
	assign command    = out_res.command;
	assign length     = out_res.length;
	assign status     = out_res.status;
	assign first_word = out_res.first_word;

endmodule
`default_nettype wire

// File: dv/frame_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_result_checker: predicts and checks the CRC-16 frame receiver
// Watches the config, byte and result channels. Every accepted byte request
// runs through a local deframer that queues the results it should cause.
// Every accepted result is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module frame_result_checker
	import crcfr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	input  wire logic               cfg_ready,
	input  wire logic [7:0]         cfg_data,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic [7:0]         rx_byte,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic               kind,
	input  wire logic [7:0]         data_byte,
	input  wire logic [7:0]         byte_index,
	input  wire logic [7:0]         command,
	input  wire logic [7:0]         length,
	input  wire logic [1:0]         status,
	input  wire logic signed [15:0] first_word,
	output int                      failures,
	output int                      results_waiting
);

	// Local copy of the deframer state and of the length limit.
	phase_t      frame_phase;
	logic [15:0] running_crc;
	logic [7:0]  frame_len;
	logic [7:0]  frame_cmd;
	logic [7:0]  payload_pos;
	logic [7:0]  crc_hi_seen;
	logic [15:0] lead_word;
	logic [7:0]  payload_limit;
	result_t     frame_results_due[$];
	int          errors = 0;

	initial begin
		failures = 0;
		results_waiting = 0;
	end

	// Reflected CRC-16 step, one data bit at a time.
	function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r = r >> 1;
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	task automatic queue_result(input logic k, input logic [7:0] d, input logic [7:0] idx,
			input status_t st, input logic [15:0] w);
		result_t r;
		r.kind = k;
		r.data_byte = d;
		r.byte_index = idx;
		r.command = frame_cmd;
		r.length = frame_len;
		r.status = st;
		r.first_word = w;
		frame_results_due.push_back(r);
	endtask

	// Advance the deframer by one received byte.
	task automatic deframe_byte(input logic [7:0] b);
		case (frame_phase)
			PH_HUNT_A5: begin
				if (b == HDR_BYTE0) begin
					frame_phase = PH_HUNT_5A;
				end
			end
			PH_HUNT_5A: begin
				if (b == HDR_BYTE1) begin
					running_crc = crc16_update(crc16_update(CRC_INIT, HDR_BYTE0), HDR_BYTE1);
					frame_phase = PH_LEN;
				end else if (b != HDR_BYTE0) begin
					frame_phase = PH_HUNT_A5;
				end
			end
			PH_LEN: begin
				frame_len = b;
				running_crc = crc16_update(running_crc, b);
				frame_phase = PH_CMD;
			end
			PH_CMD: begin
				frame_cmd = b;
				running_crc = crc16_update(running_crc, b);
				payload_pos = 8'd0;
				lead_word = 16'd0;
				if (frame_len > payload_limit) begin
					frame_phase = PH_HUNT_A5;
					queue_result(KIND_END, 8'd0, 8'd0, ST_TOO_LONG, 16'd0);
				end else if (frame_len == 8'd0) begin
					frame_phase = PH_CRC_HI;
				end else begin
					frame_phase = PH_DATA;
				end
			end
			PH_DATA: begin
				running_crc = crc16_update(running_crc, b);
				if (payload_pos == 8'd0) begin
					lead_word[15:8] = b;
				end else if (payload_pos == 8'd1) begin
					lead_word[7:0] = b;
				end
				queue_result(KIND_DATA, b, payload_pos, ST_OK, 16'd0);
				payload_pos = payload_pos + 8'd1;
				if (payload_pos == frame_len) begin
					frame_phase = PH_CRC_HI;
				end
			end
			PH_CRC_HI: begin
				crc_hi_seen = b;
				frame_phase = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				frame_phase = PH_HUNT_A5;
				if ({crc_hi_seen, b} == running_crc) begin
					queue_result(KIND_END, 8'd0, 8'd0, ST_OK, lead_word);
				end else begin
					queue_result(KIND_END, 8'd0, 8'd0, ST_CRC_ERR, lead_word);
				end
			end
			default: begin
				frame_phase = PH_HUNT_A5;
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Sample all three channels at each clock edge.
	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			frame_phase = PH_HUNT_A5;
			running_crc = CRC_INIT;
			frame_len = 8'd0;
			frame_cmd = 8'd0;
			payload_pos = 8'd0;
			crc_hi_seen = 8'd0;
			lead_word = 16'd0;
			payload_limit = MAX_PAY_RST;
			frame_results_due.delete();
			results_waiting <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				payload_limit = cfg_data;
			end
			if (in_valid && in_ready) begin
				deframe_byte(rx_byte);
			end
			if (out_valid && out_ready) begin
				if (frame_results_due.size() == 0) begin
					$display("%0t: result with none expected, kind %0h status %0h",
						$time, kind, status);
					errors++;
				end else begin
					want = frame_results_due.pop_front();
					check_field("kind", 16'(want.kind), 16'(kind));
					check_field("data_byte", 16'(want.data_byte), 16'(data_byte));
					check_field("byte_index", 16'(want.byte_index), 16'(byte_index));
					check_field("command", 16'(want.command), 16'(command));
					check_field("length", 16'(want.length), 16'(length));
					check_field("status", 16'(want.status), 16'(status));
					check_field("first_word", want.first_word, first_word);
				end
			end
			results_waiting <= frame_results_due.size();
		end
		failures <= errors;
	end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top for the CRC-16 frame receiver
// Drives received bytes and length limits, throttles the result side and
// gives the verdict; prediction and comparison live in the checker.
// ----------------------------------------------------------------------------
module tb
	import crcfr_pkg::*;
();

	localparam int         CYCLE_LIMIT  = 150000;
	localparam int         PHASE_ITEMS  = 145;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         DRAIN_CYCLES = 4;
	localparam logic [7:0] TRAILER_BYTE = 8'hFF;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic [7:0]        cfg_data = 8'd0;
	logic              in_valid = 1'b0;
	logic [7:0]        rx_byte = 8'd0;
	logic              out_ready = 1'b0;
	logic              cfg_ready;
	logic              in_ready;
	logic              out_valid;
	logic              kind;
	logic [7:0]        data_byte;
	logic [7:0]        byte_index;
	logic [7:0]        command;
	logic [7:0]        length;
	logic [1:0]        status;
	logic signed [15:0] first_word;

	int                failures;
	int                results_waiting;
	int                cycle_count = 0;
	int                sent_count = 0;
	bit                calm = 1'b0;
	bit                hold_req = 1'b0;
	logic [7:0]        cur_max = MAX_PAY_RST;
	logic [7:0]        frame_data[$];

	crc16_frame_receiver uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.data_byte(data_byte),
		.byte_index(byte_index),
		.command(command),
		.length(length),
		.status(status),
		.first_word(first_word)
	);

	frame_result_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.data_byte(data_byte),
		.byte_index(byte_index),
		.command(command),
		.length(length),
		.status(status),
		.first_word(first_word),
		.failures(failures),
		.results_waiting(results_waiting)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Give up if the run hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result side: random back-pressure, plus one long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(0, 99) >= 12);
			end
		end
	end

	// Offer one byte request, with an occasional gap in front of it.
	task automatic send_byte(input logic [7:0] b);
		if (!calm && $urandom_range(0, 99) < 12) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_count++;
	endtask

	// Send a complete frame around frame_data; crc_flip corrupts the check.
	task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd,
			input logic [15:0] crc_flip);
		logic [15:0] c;
		c = crc_byte(crc_byte(CRC_AFTER_HDR, len), cmd);
		foreach (frame_data[i]) c = crc_byte(c, frame_data[i]);
		c = c ^ crc_flip;
		send_byte(HDR_BYTE0);
		send_byte(HDR_BYTE1);
		send_byte(len);
		send_byte(cmd);
		foreach (frame_data[i]) send_byte(frame_data[i]);
		send_byte(c[15:8]);
		send_byte(c[7:0]);
	endtask

	task automatic fill_payload(input int n);
		frame_data.delete();
		repeat (n) frame_data.push_back(8'($urandom_range(0, 255)));
	endtask

	// Stop offering and wait until every expected result has come out.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_waiting != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cur_max = v;
	endtask

	// One random piece of traffic: mostly frames, some broken headers and noise.
	task automatic random_burst();
		int pick;
		int len;
		logic [15:0] flip;
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				len = $urandom_range(0, 5);
			end else if (pick < 80) begin
				len = $urandom_range(6, 20);
			end else if (pick < 95) begin
				len = int'(cur_max) + $urandom_range(0, 1);
			end else begin
				len = $urandom_range(21, 48);
			end
			if (len > 255) begin
				len = 255;
			end
			// A too-long frame's tail is idle, so keep it short.
			fill_payload((len > int'(cur_max) && len > 6) ? 6 : len);
			flip = ($urandom_range(0, 9) == 0) ? 16'(1 << $urandom_range(0, 15)) : 16'h0;
			send_frame(8'(len), 8'($urandom_range(0, 255)), flip);
			if ($urandom_range(0, 1) == 1) begin
				send_byte(TRAILER_BYTE);
			end
		end else if (pick < 87) begin
			send_byte(HDR_BYTE0);
			if ($urandom_range(0, 1) == 1) begin
				send_byte(HDR_BYTE0);
			end
			send_byte(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// Stimulus and verdict.
	initial begin : stimulus
		logic [7:0] limits[7];
		int start;
		limits = '{8'd255, 8'd0, 8'd254, 8'd4, 8'd0, 8'd1, 8'd255};
		limits[4] = 8'($urandom_range(2, 253));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle bytes while hunting.
		send_byte(8'h00);
		send_byte(TRAILER_BYTE);
		// Repeated A5 ahead of a frame whose first word is negative.
		send_byte(HDR_BYTE0);
		frame_data = '{8'hFF, 8'h80};
		send_frame(8'd2, 8'h00, 16'h0);
		// Empty payload, straight after the previous frame.
		frame_data.delete();
		send_frame(8'd0, 8'hFF, 16'h0);
		// Broken header.
		send_byte(HDR_BYTE0);
		send_byte(8'h00);
		// Too long with the limit at zero.
		settle();
		write_limit(8'd0);
		frame_data.delete();
		send_frame(8'd1, 8'hCC, 16'h0);

		// Random traffic under a series of length limits.
		for (int p = 0; p < 7; p++) begin
			settle();
			write_limit(limits[p]);
			calm = (p == 3);
			start = sent_count;
			if (p == 0) begin
				fill_payload(255);
				send_frame(8'd255, 8'($urandom_range(0, 255)), 16'h0);
			end
			if (p == 2) begin
				hold_req = 1'b1;
				frame_data.delete();
				send_frame(8'd255, 8'($urandom_range(0, 255)), 16'h0);
			end
			while (sent_count - start < PHASE_ITEMS) random_burst();
		end
		calm = 1'b0;

		settle();
		if (failures == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: crc16_frame_receiver.f
rtl/crcfr_pkg.sv
rtl/crcfr_deframer.sv
rtl/crcfr_out_reg.sv
rtl/crc16_frame_receiver.sv
dv/frame_result_checker.sv
dv/tb.sv
